### sv/coin_credit_input_controller_defines.svh
// assertion macros used by the checker file
`ifndef COIN_CREDIT_INPUT_CONTROLLER_DEFINES_SVH
`define COIN_CREDIT_INPUT_CONTROLLER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CCI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication with the consequent in the next cycle
`define CCI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/cci_pkg.sv
// types, command codes and helpers of the coin and credit input controller
`default_nettype none
package cci_pkg;

   // one bus access
   typedef struct packed {
      logic       op;
      logic [7:0] wdata;
      logic [3:0] in0;
      logic [3:0] in1;
      logic [3:0] in2;
      logic [3:0] in3;
   } cci_req_type;

   // one access result
   typedef struct packed {
      logic [7:0] rdata;
      logic       fault;
   } cci_rsp_type;

   typedef enum logic [1:0] {
      MODE_UNKNOWN = 2'd0,
      MODE_CREDIT  = 2'd1,
      MODE_SWITCH  = 2'd2
   } cci_mode_type;

   localparam logic       OP_WRITE = 1'b0;
   localparam logic       OP_READ  = 1'b1;

   localparam logic [7:0] CMD_COINAGE   = 8'd1;
   localparam logic [7:0] CMD_CREDIT    = 8'd2;
   localparam logic [7:0] CMD_REMAP_OFF = 8'd3;
   localparam logic [7:0] CMD_REMAP_ON  = 8'd4;
   localparam logic [7:0] CMD_SWITCH    = 8'd5;

   localparam logic [2:0] COINAGE_BYTES = 3'd4;
   localparam logic [6:0] CREDIT_MAX    = 7'd99;
   localparam logic [1:0] SLOT_KEYS     = 2'd0;
   localparam logic [1:0] SLOT_JOY1     = 2'd1;
   localparam logic [1:0] SLOT_LAST     = 2'd2;

   // count (0..99) to two bcd digits; tens by reciprocal 103/1024
   function automatic logic [7:0] cci_to_bcd(input logic [6:0] count);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = {7'd0, count} * 14'd103;
      tens     = prod[13:10];
      tens_x10 = {tens, 3'b000} - {3'b000, tens} + {2'b00, tens, 1'b0} + {3'b000, tens};
      ones     = count - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage
`default_nettype wire

### sv/cci_engine.sv
// architectural state and per-access decode of the controller
`default_nettype none
module cci_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire cci_pkg::cci_req_type req,
   output cci_pkg::cci_rsp_type      rsp
);
   import cci_pkg::*;

   cci_mode_type mode_ff, mode_in;
   logic         remap_on_ff, remap_on_in;
   logic [6:0]   credit_ff, credit_in;
   logic [2:0]   skip_ff, skip_in;
   logic [1:0]   slot_ff, slot_in;
   logic [3:0]   keys_ff, keys_in;   // key byte bits 5..2
   logic [1:0]   last_fire_ff, last_fire_in;

   logic [3:0]   keys_now;
   logic [3:0]   keys_rise;
   logic [6:0]   cnt_a, cnt_b, cnt_c, cnt_d;
   logic [1:0]   held;
   logic         sel;

   // next state and read data
   always_comb begin
      mode_in      = mode_ff;
      remap_on_in  = remap_on_ff;
      credit_in    = credit_ff;
      skip_in      = skip_ff;
      slot_in      = slot_ff;
      keys_in      = keys_ff;
      last_fire_in = last_fire_ff;
      rsp          = '0;

      keys_now  = {~req.in1[1:0], ~req.in0[3:2]};
      keys_rise = keys_now & ~keys_ff;
      cnt_a = (keys_rise[3] && credit_ff < CREDIT_MAX) ? credit_ff + 7'd1 : credit_ff;
      cnt_b = (keys_rise[2] && cnt_a < CREDIT_MAX) ? cnt_a + 7'd1 : cnt_a;
      cnt_c = (keys_rise[1] && cnt_b >= 7'd2) ? cnt_b - 7'd2 : cnt_b;
      cnt_d = (keys_rise[0] && cnt_c >= 7'd1) ? cnt_c - 7'd1 : cnt_c;

      held = ~req.in0[1:0];
      sel  = (slot_ff != SLOT_JOY1);

      if (req.op == OP_WRITE) begin
         if (skip_ff != 3'd0) begin
            skip_in = skip_ff - 3'd1;
         end else begin
            case (req.wdata)
               CMD_COINAGE:   skip_in = COINAGE_BYTES;
               CMD_CREDIT: begin
                  mode_in = MODE_CREDIT;
                  slot_in = SLOT_KEYS;
               end
               CMD_REMAP_OFF: remap_on_in = 1'b0;
               CMD_REMAP_ON:  remap_on_in = 1'b1;
               CMD_SWITCH: begin
                  mode_in = MODE_SWITCH;
                  slot_in = SLOT_KEYS;
               end
               default: ;
            endcase
         end
      end else if (mode_ff == MODE_SWITCH || mode_ff == MODE_CREDIT) begin
         slot_in = (slot_ff >= SLOT_LAST) ? SLOT_KEYS : slot_ff + 2'd1;
         if (mode_ff == MODE_SWITCH) begin
            // raw port nibbles
            if (slot_ff == SLOT_KEYS) begin
               rsp.rdata = {req.in1, req.in0};
            end else if (slot_ff == SLOT_JOY1) begin
               rsp.rdata = {req.in3, req.in2};
            end
         end else if (slot_ff == SLOT_KEYS) begin
            // coin and start edges, credits out as bcd
            credit_in = cnt_d;
            keys_in   = keys_now;
            rsp.rdata = cci_to_bcd(cnt_d);
         end else if (remap_on_ff) begin
            rsp.fault = 1'b1;
         end else begin
            // joystick with fire press edge and held flags
            rsp.rdata = {2'b00, ~held[sel], ~(held[sel] & ~last_fire_ff[sel]),
                         sel ? req.in3 : req.in2};
            last_fire_in[sel] = held[sel];
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UNKNOWN;
         remap_on_ff  <= 1'b0;
         credit_ff    <= 7'd0;
         skip_ff      <= 3'd0;
         slot_ff      <= 2'd0;
         keys_ff      <= 4'd0;
         last_fire_ff <= 2'd0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         remap_on_ff  <= remap_on_in;
         credit_ff    <= credit_in;
         skip_ff      <= skip_in;
         slot_ff      <= slot_in;
         keys_ff      <= keys_in;
         last_fire_ff <= last_fire_in;
      end
   end

endmodule
`default_nettype wire

### sv/coin_credit_input_controller.sv
// top level of the coin and credit input controller
//
// The req channel carries one bus access per beat: op selects a command
// byte write or a read, and the four port nibbles are sampled with it.
// The rsp channel returns exactly one beat per access: the read byte and
// the fault flag (writes return zero).
// An accepted beat lands in an input register; from there it runs
// through the decode and state update into the result register, whose
// valid flag is rsp_valid; the move waits while a stalled response holds.
// Throughput is one access per cycle while responses drain, set by the
// single state update per beat; the input register can still take a
// new request while a finished response waits, if it is empty.
// When rsp_ready is low the response holds and one more request can sit
// in the input register; req_ready then drops until the response goes.
// Reset clears both registers' valid flags and all controller state:
// mode unknown, remap off, zero credits, no coinage bytes pending.
`default_nettype none
module coin_credit_input_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire cci_pkg::cci_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cci_pkg::cci_rsp_type      rsp_data
);
   import cci_pkg::*;

   logic        in_valid_ff, in_valid_in;
   cci_req_type in_data_ff;
   logic        out_valid_ff, out_valid_in;
   cci_rsp_type out_data_ff;
   cci_rsp_type result;
   logic        advance;

   // pipeline moves when the result register is free or being drained
   assign advance      = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   cci_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (in_valid_ff && advance),
      .req   (in_data_ff),
      .rsp   (result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req_ready ? in_valid_in : in_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (in_valid_ff && advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

### sv/cci_checker.sv
// port-level checks of the controller and their bind
`default_nettype none
`include "coin_credit_input_controller_defines.svh"
module cci_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire cci_pkg::cci_req_type req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire cci_pkg::cci_rsp_type rsp_data
);
   import cci_pkg::*;

   // a stalled response beat stays
   `CCI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // a fault read never carries data
   `CCI_ASSERT_IMP(a_fault_zero, rsp_valid && rsp_data.fault, rsp_data.rdata == 8'd0)
   // with the output empty the input side is open
   `CCI_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready)
   // a stalled request beat stays
   `CCI_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data))

endmodule

bind coin_credit_input_controller cci_checker u_cci_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
